[design/fcaxy_pkg.sv]
// Package for the full-circle angle block: pipeline record type, fixed-point
// constants and the arctangent step table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcaxy_pkg;

    localparam int DEF_COORD_WIDTH     = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 13;

    localparam int ZFRAC     = 30;
    localparam int NSTEPS    = 32;
    localparam int SCALE_TOP = 58;
    localparam int UV_W      = 60;
    localparam int Z_W       = 32;
    localparam int T_W       = 34;

    localparam logic [T_W-1:0] HALF_PI_Z  = 34'd1686629713;
    localparam logic [T_W-1:0] PI_Z       = 34'd3373259426;
    localparam logic [T_W-1:0] THREE_HP_Z = 34'd5059889139;
    localparam logic [T_W-1:0] TWO_PI_Z   = 34'd6746518852;

    typedef struct packed {
        logic            vld;
        logic            zero;
        logic [1:0]      quad;
        logic [UV_W-1:0] u;
        logic [UV_W-1:0] v;
        logic [Z_W-1:0]  z;
    } t_cordic;

    function automatic logic [Z_W-1:0] atan_z(input int idx);
        logic [Z_W-1:0] r;
        case (idx)
            0:       r = 32'h3243F6A8;
            1:       r = 32'h1DAC6705;
            2:       r = 32'h0FADBAFC;
            3:       r = 32'h07F56EA6;
            4:       r = 32'h03FEAB76;
            5:       r = 32'h01FFD55B;
            6:       r = 32'h00FFFAAA;
            7:       r = 32'h007FFF55;
            8:       r = 32'h003FFFEA;
            9:       r = 32'h001FFFFD;
            10:      r = 32'h000FFFFF;
            11:      r = 32'h0007FFFF;
            12:      r = 32'h0003FFFF;
            13:      r = 32'h0001FFFF;
            14:      r = 32'h0000FFFF;
            15:      r = 32'h00007FFF;
            16:      r = 32'h00003FFF;
            17:      r = 32'h00001FFF;
            18:      r = 32'h00000FFF;
            19:      r = 32'h000007FF;
            20:      r = 32'h000003FF;
            21:      r = 32'h000001FF;
            22:      r = 32'h000000FF;
            23:      r = 32'h0000007F;
            24:      r = 32'h0000003F;
            25:      r = 32'h0000001F;
            26:      r = 32'h0000000F;
            27:      r = 32'h00000008;
            28:      r = 32'h00000004;
            29:      r = 32'h00000002;
            30:      r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // Rounded value of two pi in the output format; it wraps to zero.
    function automatic longint angle_full(input int afb);
        longint sh;
        sh = longint'(ZFRAC - afb);
        return (longint'(TWO_PI_Z) + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

endpackage

`default_nettype wire

[design/full_circle_angle_from_xy_top.sv]
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: x_coord, y_coord
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: angle; tuser: zero_vector
//
// One transfer is accepted per cycle while the pipeline is not stalled. The
// transfer lands in the fold stage, then passes 32 vectoring stages, three
// output arithmetic stages and the output register.
// Reset clears only the valid bits. An output stall is absorbed by a skid
// entry; the pipeline then holds until it drains.
// Top level of the full-circle angle block. Depends on fcaxy_pkg and all
// fcaxy_* modules.
`timescale 1ns / 1ps
`default_nettype none

module full_circle_angle_from_xy_top #(
    parameter int COORD_WIDTH     = fcaxy_pkg::DEF_COORD_WIDTH,
    parameter int ANGLE_FRAC_BITS = fcaxy_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    // x_coord, y_coord
    input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    // angle
    output logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0]        m_axis_tdata,
    // zero_vector
    output logic [0:0]                                    m_axis_tuser
);
    import fcaxy_pkg::*;

    localparam int            AW     = ANGLE_FRAC_BITS + 3;
    localparam int            OUT_DW = ((AW + 7) / 8) * 8;
    localparam logic [AW-1:0] FULL   = AW'(angle_full(ANGLE_FRAC_BITS));

    logic          en;
    t_cordic       pipe [NSTEPS+1];
    logic          post_vld, post_zero;
    logic [AW-1:0] post_angle;
    logic [AW:0]   out_data;

    assign s_axis_tready = en;

    fcaxy_prep #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_prep (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (s_axis_tvalid),
        .i_x    (s_axis_tdata[COORD_WIDTH-1:0]),
        .i_y    (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .o_q    (pipe[0])
    );

    for (genvar i = 0; i < NSTEPS; i++) begin : g_step
        fcaxy_stage #(
            .STEP(i)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_q    (pipe[i]),
            .o_q    (pipe[i+1])
        );
    end

    fcaxy_post #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_post (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_q    (pipe[NSTEPS]),
        .o_vld  (post_vld),
        .o_zero (post_zero),
        .o_angle(post_angle)
    );

    fcaxy_skid #(
        .DW(AW + 1)
    ) u_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .o_en   (en),
        .i_vld  (post_vld),
        .i_data ({post_zero, post_angle}),
        .o_vld  (m_axis_tvalid),
        .o_data (out_data),
        .i_rdy  (m_axis_tready)
    );

    assign m_axis_tdata    = OUT_DW'(out_data[AW-1:0]);
    assign m_axis_tuser[0] = out_data[AW];

`ifndef SYNTH
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> out_data[AW-1:0] == '0)
        else $error("Zero vector result carries a nonzero angle.");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> out_data[AW-1:0] < FULL)
        else $error("Angle is not below one full turn.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready || m_axis_tvalid)
        else $error("Input stalled while no result is held.");

    a_post_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        post_vld && en |=> m_axis_tvalid)
        else $error("Finished result was not transferred to the output.");
`endif

endmodule

`default_nettype wire

[design/fcaxy_prep.sv]
// Input stage: folds the vector into the first quadrant and scales it.
// Depends on fcaxy_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcaxy_prep #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_vld,
    input  wire logic [COORD_WIDTH-1:0] i_x,
    input  wire logic [COORD_WIDTH-1:0] i_y,
    output fcaxy_pkg::t_cordic          o_q
);
    import fcaxy_pkg::*;

    localparam int PRESHIFT = SCALE_TOP - COORD_WIDTH;

    logic [COORD_WIDTH:0] x_ext, y_ext, x_neg, y_neg, mag_u, mag_v;
    logic                 x_pos, x_lt0, y_pos, y_lt0, x_nz, y_nz;
    t_cordic              r_q, n_q;

    always_comb begin
        x_ext = {i_x[COORD_WIDTH-1], i_x};
        y_ext = {i_y[COORD_WIDTH-1], i_y};
        x_neg = -x_ext;
        y_neg = -y_ext;
        x_nz  = |i_x;
        y_nz  = |i_y;
        x_lt0 = i_x[COORD_WIDTH-1];
        y_lt0 = i_y[COORD_WIDTH-1];
        x_pos = x_nz && !x_lt0;
        y_pos = y_nz && !y_lt0;
        if (x_pos && !y_lt0) begin
            n_q.quad = 2'd0;
            mag_u    = x_ext;
            mag_v    = y_ext;
        end else if (!x_pos && y_pos) begin
            n_q.quad = 2'd1;
            mag_u    = y_ext;
            mag_v    = x_neg;
        end else if (x_lt0 && !y_pos) begin
            n_q.quad = 2'd2;
            mag_u    = x_neg;
            mag_v    = y_neg;
        end else begin
            n_q.quad = 2'd3;
            mag_u    = y_neg;
            mag_v    = x_ext;
        end
        n_q.vld  = i_vld;
        n_q.zero = !x_nz && !y_nz;
        n_q.u    = UV_W'(mag_u) << PRESHIFT;
        n_q.v    = UV_W'(mag_v) << PRESHIFT;
        n_q.z    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

[design/fcaxy_stage.sv]
// One vectoring step of the rotation pipeline, with its own register.
// Depends on fcaxy_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcaxy_stage #(
    parameter int STEP = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  fcaxy_pkg::t_cordic i_q,
    output fcaxy_pkg::t_cordic o_q
);
    import fcaxy_pkg::*;

    localparam logic [Z_W-1:0] STEP_ANGLE = atan_z(STEP);

    logic signed [UV_W-1:0] du, dv;
    logic                   v_neg, v_pos;
    t_cordic                r_q, n_q;

    always_comb begin
        dv    = $signed(i_q.v) >>> STEP;
        du    = $signed(i_q.u) >>> STEP;
        v_neg = i_q.v[UV_W-1];
        v_pos = !v_neg && (|i_q.v);
        n_q   = i_q;
        if (v_pos) begin
            n_q.u = i_q.u + dv;
            n_q.v = i_q.v - du;
            n_q.z = i_q.z + STEP_ANGLE;
        end else if (v_neg) begin
            n_q.u = i_q.u - dv;
            n_q.v = i_q.v + du;
            n_q.z = i_q.z - STEP_ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

[design/fcaxy_post.sv]
// Output arithmetic: quadrant offset, wrap into one turn, rounding to the
// output format. Three register stages. Depends on fcaxy_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcaxy_post #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  fcaxy_pkg::t_cordic              i_q,
    output logic                            o_vld,
    output logic                            o_zero,
    output logic [ANGLE_FRAC_BITS+2:0]      o_angle
);
    import fcaxy_pkg::*;

    localparam int                   AW   = ANGLE_FRAC_BITS + 3;
    localparam int                   SH   = ZFRAC - ANGLE_FRAC_BITS;
    localparam logic [T_W-2:0]       HALF = (T_W-1)'(1) << (SH - 1);
    localparam logic [AW-1:0]        FULL = AW'(angle_full(ANGLE_FRAC_BITS));

    logic [2:0]     r_vld;
    logic [2:0]     r_zero;
    logic [T_W-1:0] r_t, n_t, offs;
    logic [T_W-2:0] r_w, n_w;
    logic [AW-1:0]  r_a, n_a;
    logic [T_W-2:0] rsum;

    always_comb begin
        case (i_q.quad)
            2'd0:    offs = '0;
            2'd1:    offs = HALF_PI_Z;
            2'd2:    offs = PI_Z;
            2'd3:    offs = THREE_HP_Z;
            default: offs = '0;
        endcase
        n_t = offs + {{(T_W-Z_W){i_q.z[Z_W-1]}}, i_q.z};

        if (r_t[T_W-1]) begin
            n_w = (T_W-1)'(r_t + TWO_PI_Z);
        end else if (r_t >= TWO_PI_Z) begin
            n_w = (T_W-1)'(r_t - TWO_PI_Z);
        end else begin
            n_w = r_t[T_W-2:0];
        end

        rsum = r_w + HALF;
        n_a  = rsum[T_W-2:SH];
        if (r_zero[1] || n_a >= FULL) begin
            n_a = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld  <= {r_vld[1:0], i_q.vld};
            r_zero <= {r_zero[1:0], i_q.zero};
            r_t    <= n_t;
            r_w    <= n_w;
            r_a    <= n_a;
        end
    end

    assign o_vld   = r_vld[2];
    assign o_zero  = r_zero[2];
    assign o_angle = r_a;

endmodule

`default_nettype wire

[design/fcaxy_skid.sv]
// Output register with a skid entry; stalls the pipeline only when both
// are full. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fcaxy_skid #(
    parameter int DW = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    output logic               o_en,
    input  wire logic          i_vld,
    input  wire logic [DW-1:0] i_data,
    output logic               o_vld,
    output logic [DW-1:0]      o_data,
    input  wire logic          i_rdy
);

    logic          r_out_v, r_sk_v;
    logic [DW-1:0] r_out, r_sk;
    logic          take;

    assign take = r_out_v && i_rdy;
    assign o_en = !r_sk_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (!r_sk_v && i_vld) begin
            if (!r_out_v || take) begin
                r_out   <= i_data;
                r_out_v <= 1'b1;
            end else begin
                r_sk   <= i_data;
                r_sk_v <= 1'b1;
            end
        end else if (take) begin
            if (r_sk_v) begin
                r_out  <= r_sk;
                r_sk_v <= 1'b0;
            end else begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_vld  = r_out_v;
    assign o_data = r_out;

endmodule

`default_nettype wire

[tb/sv/fcaxy_angle_checker.sv]
// Checker for the full-circle angle block: watches the input and result channels,
// predicts the angle of every accepted vector and compares results in order.
// Depends on fcaxy_pkg for widths and fixed-point constants.
`timescale 1ns / 1ps

module fcaxy_angle_checker (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_s_tvalid,
    input  wire logic                                        i_s_tready,
    // x_coord, y_coord
    input  wire logic [2*fcaxy_pkg::DEF_COORD_WIDTH-1:0]     i_s_tdata,
    input  wire logic                                        i_m_tvalid,
    input  wire logic                                        i_m_tready,
    // angle
    input  wire logic [fcaxy_pkg::DEF_ANGLE_FRAC_BITS+2:0]   i_m_tdata,
    // zero_vector
    input  wire logic [0:0]                                  i_m_tuser,
    output int                                               o_fail_count,
    output int                                               o_outstanding
);

    localparam int CW       = fcaxy_pkg::DEF_COORD_WIDTH;
    localparam int AFB      = fcaxy_pkg::DEF_ANGLE_FRAC_BITS;
    localparam int AW       = AFB + 3;
    localparam int PRESHIFT = fcaxy_pkg::SCALE_TOP - CW;
    localparam int STEPS    = fcaxy_pkg::NSTEPS;
    localparam int MAX_SHOWN = 10;

    localparam longint QUARTER_TURN = longint'(fcaxy_pkg::HALF_PI_Z);
    localparam longint FULL_TURN    = longint'(fcaxy_pkg::TWO_PI_Z);

    // Arctangent of 2^-i in units of 2^-30 rad; steps 27 to 30 are rounded up, the rest truncated.
    localparam longint ATAN_STEP [STEPS] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
        64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008,
        64'h00000004, 64'h00000002, 64'h00000001, 64'h00000000
    };

    typedef struct packed {
        logic [AW-1:0] angle;
        logic          zero_vector;
    } t_polar;

    t_polar polar_q[$];
    int     mismatches = 0;

    function automatic t_polar angle_of_vector(input logic signed [CW-1:0] xc,
                                               input logic signed [CW-1:0] yc);
        t_polar res;
        longint xs, ys, u, v, z, du, dv, t, a, full;
        int     quarters;
        int     sh;
        xs = longint'(xc);
        ys = longint'(yc);
        res.angle = '0;
        res.zero_vector = 1'b0;
        if (xs == 0 && ys == 0) begin
            res.zero_vector = 1'b1;
            return res;
        end
        // Fold into x > 0, y >= 0 and remember how many quarter turns that took.
        if (xs > 0 && ys >= 0) begin
            quarters = 0; u = xs; v = ys;
        end else if (xs <= 0 && ys > 0) begin
            quarters = 1; u = ys; v = -xs;
        end else if (xs < 0 && ys <= 0) begin
            quarters = 2; u = -xs; v = -ys;
        end else begin
            quarters = 3; u = -ys; v = xs;
        end
        u = u <<< PRESHIFT;
        v = v <<< PRESHIFT;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dv = v >>> i;
            du = u >>> i;
            if (v > 0) begin
                u = u + dv;
                v = v - du;
                z = z + ATAN_STEP[i];
            end else if (v < 0) begin
                u = u - dv;
                v = v + du;
                z = z - ATAN_STEP[i];
            end
        end
        t = longint'(quarters) * QUARTER_TURN + z;
        if (t < 0) begin
            t = t + FULL_TURN;
        end
        if (t >= FULL_TURN) begin
            t = t - FULL_TURN;
        end
        sh = fcaxy_pkg::ZFRAC - AFB;
        a = (t + (longint'(1) <<< (sh - 1))) >>> sh;
        full = (FULL_TURN + (longint'(1) <<< (sh - 1))) >>> sh;
        if (a >= full) begin
            a = 0;
        end
        res.angle = a[AW-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_polar expected;
        if (i_rst_n && i_s_tvalid && i_s_tready) begin
            polar_q.push_back(angle_of_vector(i_s_tdata[CW-1:0], i_s_tdata[2*CW-1:CW]));
        end
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            if (polar_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("%0t: unexpected result angle=%0d zero_vector=%0d", $realtime,
                             i_m_tdata[AW-1:0], i_m_tuser[0]);
                end
            end else begin
                expected = polar_q.pop_front();
                if (i_m_tdata[AW-1:0] !== expected.angle
                        || i_m_tuser[0] !== expected.zero_vector) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("%0t: mismatch angle exp=%0d act=%0d zero_vector exp=%0d act=%0d",
                                 $realtime, expected.angle, i_m_tdata[AW-1:0],
                                 expected.zero_vector, i_m_tuser[0]);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_outstanding <= polar_q.size();
    end

endmodule

[tb/sv/full_circle_angle_from_xy_top_test.sv]
// Testbench top for the full-circle angle block: drives vectors with random gaps,
// stalls the result side and reports the verdict of the checker.
// Depends on fcaxy_pkg, full_circle_angle_from_xy_top and fcaxy_angle_checker.
`timescale 1ns / 1ps

module full_circle_angle_from_xy_top_test;

    localparam int CW         = fcaxy_pkg::DEF_COORD_WIDTH;
    localparam int AW         = fcaxy_pkg::DEF_ANGLE_FRAC_BITS + 3;
    localparam int RAND_ITEMS = 1750;
    localparam int QUIET_FROM = 1500;
    localparam int DIR_N      = 22;

    localparam int DIR_X [DIR_N] = '{
        0, 32767, -32768, 0, 0, -32768, 32767, -32768, 32767, 1, -1,
        0, 0, 1, -1, 32767, 32767, -32768, -32768, 1, -32768, 12345
    };
    localparam int DIR_Y [DIR_N] = '{
        0, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768, 0, 0,
        1, -1, 1, -1, -1, -2, -1, 1, -1, 0, -6789
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [2*CW-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [AW-1:0]     m_axis_tdata;
    logic [0:0]        m_axis_tuser;

    int fail_count;
    int outstanding;
    bit quiet = 1'b0;
    int stall_left = 0;

    always #5 i_clk = ~i_clk;

    full_circle_angle_from_xy_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fcaxy_angle_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_vector(input logic [CW-1:0] xv, input logic [CW-1:0] yv);
        int gap;
        if (!quiet && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {yv, xv};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [CW-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'hFFFF;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    initial begin
        logic [CW-1:0] xv;
        logic [CW-1:0] yv;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int n = 0; n < DIR_N; n++) begin
            send_vector(CW'(DIR_X[n]), CW'(DIR_Y[n]));
        end
        for (int n = 0; n < RAND_ITEMS; n++) begin
            quiet = (n >= QUIET_FROM);
            xv = CW'($urandom);
            yv = CW'($urandom);
            case ($urandom_range(0, 9))
                5: begin
                    xv = CW'(int'($urandom_range(0, 16)) - 8);
                    yv = CW'(int'($urandom_range(0, 16)) - 8);
                end
                6: begin
                    if ($urandom_range(0, 1) == 0) begin
                        xv = '0;
                    end else begin
                        yv = '0;
                    end
                end
                7: begin
                    // Large positive x with a small negative or zero y lands next to the wrap point.
                    xv = CW'($urandom_range(16384, 32767));
                    yv = CW'(-int'($urandom_range(0, 6)));
                end
                8: begin
                    yv = $urandom_range(0, 1) ? xv : CW'(-int'(signed'(xv)));
                end
                9: begin
                    xv = pick_extreme();
                    yv = pick_extreme();
                end
                default: begin
                end
            endcase
            send_vector(xv, yv);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
design/fcaxy_pkg.sv
design/fcaxy_prep.sv
design/fcaxy_stage.sv
design/fcaxy_post.sv
design/fcaxy_skid.sv
design/full_circle_angle_from_xy_top.sv
tb/sv/fcaxy_angle_checker.sv
tb/sv/full_circle_angle_from_xy_top_test.sv
